// ===== src/region_timing_statistics_table_defines.svh =====
// Assertion macros used by the region timing statistics table back end
`ifndef REGION_TIMING_STATISTICS_TABLE_DEFINES_SVH
`define REGION_TIMING_STATISTICS_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define RTST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define RTST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/rtst_pkg.sv =====
// Shared types and constants of the region timing statistics table
package rtst_pkg;
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_REPORT   = 3'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] region_tag;
    logic [31:0] start_us;
    logic [31:0] end_us;
  } rtst_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_valid;
    logic [15:0] report_tag;
    logic [31:0] call_count;
    logic [31:0] average_us;
    logic [31:0] max_elapsed_us;
    logic [31:0] average_interval_us;
    logic        last;
  } rtst_out_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SEARCH, BK_RD, BK_RDW, BK_UPD, BK_DIV, BK_EMIT, BK_SIMPLE
  } rtst_bk_state_t;
endpackage

// ===== src/rtst_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read
module rtst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/rtst_div.sv =====
// Restoring 32-bit divider, one quotient bit per cycle, quotient 0 for a zero divisor
module rtst_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    shifted = {rem_r[31:0], q_r[31]};
    trial = shifted - {1'b0, d_r};
    if (go) begin
      q_nxt = num; d_nxt = den; rem_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted; q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign done = !busy_r && !go;
  assign quo  = (d_r == 32'd0) ? 32'd0 : q_r;
endmodule

// ===== src/rtst_front.sv =====
// Front end: takes requests and queues them for the back end
module rtst_front
  import rtst_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rtst_in_t in_data,
  output logic     q_valid,
  output rtst_in_t q_data,
  input  logic     q_pop
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  rtst_in_t fifo_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   n_r, n_nxt;
  logic push;

  assign busy    = (n_r == (AW+1)'(DEPTH));
  assign push    = start && !busy;
  assign q_valid = (n_r != '0);
  assign q_data  = fifo_r[rp_r];

  always_comb begin
    wp_nxt = wp_r; rp_nxt = rp_r; n_nxt = n_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    if (q_pop) rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    n_nxt = n_r + (AW+1)'(push) - (AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; n_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; n_r <= n_nxt;
    end
    if (push) fifo_r[wp_r] <= in_data;
  end
endmodule

// ===== src/rtst_back.sv =====
// Back end: tag search, statistics update and dump sequencing
module rtst_back
  import rtst_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      enable,
  input  logic      q_valid,
  input  rtst_in_t  q_data,
  output logic      q_pop,
  output logic      out_strobe,
  output rtst_out_t out_data
);
`include "region_timing_statistics_table_defines.svh"
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = 5 * 32;

  rtst_bk_state_t st_r, st_nxt;
  rtst_in_t  req_r;
  logic [TAG_BITS-1:0] tags_r [ENTRIES];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]  sts_r, sts_nxt;
  logic [31:0] sum_r, cc_r, mx_r, isum_r;
  logic [31:0] avg_r;
  logic        div_phase_r, div_phase_nxt;
  logic        div_wait_r, div_wait_nxt;
  logic [IW-1:0] ridx;

  logic          ram_we;
  logic [SW-1:0] ram_wd, ram_rd;
  logic [31:0] rd_sum, rd_cc, rd_mx, rd_ps, rd_is, elapsed;
  logic        div_go, div_done;
  logic [31:0] div_num, div_q;
  logic        emit_last;

  assign ridx   = idx_r[IW-1:0];
  assign {rd_sum, rd_cc, rd_mx, rd_ps, rd_is} = ram_rd;
  assign elapsed = req_r.end_us - req_r.start_us;

  rtst_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_stats (
    .clk(clk), .we(ram_we), .waddr(ridx), .wdata(ram_wd), .raddr(ridx), .rdata(ram_rd)
  );

  rtst_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(cc_r),
    .done(div_done), .quo(div_q)
  );

  // next state
  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; sts_nxt = sts_r; cnt_nxt = cnt_r;
    div_phase_nxt = div_phase_r; div_wait_nxt = div_wait_r;
    case (st_r)
      BK_IDLE: if (q_valid) begin
        idx_nxt = '0; div_phase_nxt = 1'b0; div_wait_nxt = 1'b0;
        if (q_data.command == CMD_DUMP) begin
          if (cnt_r == '0) begin sts_nxt = ST_REPORT; st_nxt = BK_SIMPLE; end
          else begin sts_nxt = ST_REPORT; st_nxt = BK_RD; end
        end else if (!enable) begin
          sts_nxt = ST_IGNORED; st_nxt = BK_SIMPLE;
        end else st_nxt = BK_SEARCH;
      end
      BK_SEARCH: begin
        if (idx_r < cnt_r && tags_r[ridx] == TAG_BITS'(req_r.region_tag)) begin
          sts_nxt = ST_UPDATED; st_nxt = BK_RD;
        end else if (idx_r >= cnt_r) begin
          if (cnt_r == CW'(ENTRIES)) begin sts_nxt = ST_DROPPED; st_nxt = BK_SIMPLE; end
          else begin sts_nxt = ST_CREATED; cnt_nxt = cnt_r + CW'(1); st_nxt = BK_SIMPLE; end
        end else idx_nxt = idx_r + CW'(1);
      end
      BK_RD:  st_nxt = BK_RDW;
      BK_RDW: st_nxt = (sts_r == ST_UPDATED) ? BK_UPD : BK_DIV;
      BK_UPD: st_nxt = BK_DIV;
      BK_DIV: begin
        // kick the divider and hold until it finishes, first for the average, then for the interval average
        if (!div_wait_r) div_wait_nxt = 1'b1;
        else if (div_done) begin
          div_wait_nxt = 1'b0;
          if (!div_phase_r) div_phase_nxt = 1'b1;
          else st_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        div_phase_nxt = 1'b0;
        if (sts_r == ST_REPORT && !emit_last) begin
          idx_nxt = idx_r + CW'(1); st_nxt = BK_RD;
        end else st_nxt = BK_IDLE;
      end
      BK_SIMPLE: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0; ram_we = 1'b0; ram_wd = ram_rd; div_go = 1'b0;
    div_num = div_phase_r ? isum_r : sum_r;
    out_strobe = 1'b0; out_data = '0;
    emit_last = (idx_r + CW'(1) == cnt_r) || (sts_r != ST_REPORT);
    case (st_r)
      BK_IDLE: q_pop = q_valid;
      BK_SEARCH: if (idx_r >= cnt_r && cnt_r != CW'(ENTRIES)) begin
        ram_we = 1'b1;
        ram_wd = {32'd0, 32'd0, 32'd0, req_r.start_us, 32'd0};
      end
      BK_UPD: begin
        ram_we = 1'b1;
        ram_wd = {sum_r, cc_r, mx_r, req_r.start_us, isum_r};
      end
      BK_DIV: div_go = !div_wait_r;
      BK_EMIT: begin
        out_strobe = 1'b1;
        out_data.status = sts_r; out_data.entry_valid = 1'b1;
        out_data.report_tag = 16'(tags_r[ridx]);
        out_data.call_count = cc_r; out_data.average_us = avg_r;
        out_data.max_elapsed_us = mx_r; out_data.average_interval_us = div_q;
        out_data.last = emit_last;
      end
      BK_SIMPLE: begin
        out_strobe = 1'b1; out_data.status = sts_r; out_data.last = 1'b1;
        out_data.entry_valid = (sts_r == ST_CREATED);
        if (sts_r != ST_REPORT) out_data.report_tag = 16'(TAG_BITS'(req_r.region_tag));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; cnt_r <= '0; idx_r <= '0; div_phase_r <= 1'b0;
      div_wait_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; div_phase_r <= div_phase_nxt;
      div_wait_r <= div_wait_nxt;
    end
    sts_r <= sts_nxt;
    if (st_r == BK_IDLE && q_valid) req_r <= q_data;
    if (st_r == BK_SEARCH && st_nxt == BK_SIMPLE && sts_nxt == ST_CREATED)
      tags_r[ridx] <= TAG_BITS'(req_r.region_tag);
    if (st_r == BK_RDW) begin
      if (sts_r == ST_UPDATED) begin
        sum_r  <= rd_sum + elapsed;
        cc_r   <= rd_cc + 32'd1;
        mx_r   <= (elapsed > rd_mx) ? elapsed : rd_mx;
        isum_r <= rd_is + (req_r.start_us - rd_ps);
      end else begin
        sum_r <= rd_sum; cc_r <= rd_cc; mx_r <= rd_mx; isum_r <= rd_is;
      end
    end
    if (st_r == BK_DIV && div_wait_r && div_done && !div_phase_r) avg_r <= div_q;
  end

  `RTST_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(ENTRIES), "entry count overflow")
  `RTST_ASSERT_IMP(a_emit_state, clk, rst_n, out_strobe, st_r == BK_EMIT || st_r == BK_SIMPLE, "strobe outside emit")
  `RTST_ASSERT_NEXT(a_emit_idle, clk, rst_n, st_r == BK_SIMPLE, st_r == BK_IDLE, "no return to idle")
endmodule

// ===== src/region_timing_statistics_table.sv =====
// Top level of the region timing statistics table
// Usage:
//  A request is taken when start is high and busy is low; in_data holds
//  command, tag and start/end times. The enable register is to be
//  written by the user over cfg_valid/cfg_ready (always ready) only
//  while the block is idle; the block itself does not enforce this.
//  Results appear on out_data for one cycle, marked by out_strobe; last
//  flags the final result of a request. The receiver cannot stall.
//  A two-entry request queue sits in front of the back end, so busy
//  rises only when two requests wait behind the one in progress.
//  Back end: a record searches the tags in order from entry 0. On a hit
//  it reads, updates and writes back the entry's statistics, runs two
//  divisions (average, average interval) and emits the result. A miss
//  creates an entry, or drops the request when the table is full; a
//  record while disabled is ignored. A dump emits each entry after both
//  divisions on the shared serial divider, or one result if empty.
//  Reset (synchronous, rst_n low) empties the table and queue and clears
//  enable; statistics memory needs no clearing pass.
module region_timing_statistics_table
  import rtst_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rtst_in_t  in_data,
  output logic      out_strobe,
  output rtst_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);
  logic enable_r;
  logic q_valid, q_pop;
  rtst_in_t q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) enable_r <= 1'b0;
    else if (cfg_valid && cfg_ready) enable_r <= cfg_data;
  end

  rtst_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  rtst_back #(.ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .enable(enable_r), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_strobe(out_strobe), .out_data(out_data)
  );
endmodule
